// ----- design/lr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants for the line rasterizer
// Command word layout passed from the front end to the drawing engine.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_W  = 9;   // internal coordinate width (x, and row incl. bit 8)
  localparam int ROW_W    = 8;   // row width at the ports
  localparam int ERR_W    = 10;  // error accumulator, two's complement
  localparam int COLOUR_W = 16;  // RGB565
  localparam int ADDR_W   = 32;  // byte address

  // item operation codes
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // one queued command word
  typedef struct packed {
    op_t                  op;
    logic                 steep;
    logic                 minor_down;
    logic [COORD_W-1:0]   major_pos;
    logic [COORD_W-1:0]   major_end;
    logic [COORD_W-1:0]   minor_pos;
    logic [COORD_W-1:0]   major_delta;
    logic [COORD_W-1:0]   minor_delta;
    logic [ERR_W-1:0]     error_init;
    logic [COLOUR_W-1:0]  colour;
  } cmd_t;

endpackage

// ----- design/lr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_front: input front end
// Accepts items, works out octant, endpoint order, deltas and the initial
// error for each, then pushes a command word per item to the queue.
// ----------------------------------------------------------------------------
module lr_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [lr_pkg::COORD_W-1:0]   start_x,
  input  logic [lr_pkg::ROW_W-1:0]     start_y,
  input  logic [lr_pkg::COORD_W-1:0]   end_x,
  input  logic [lr_pkg::ROW_W-1:0]     end_y,
  input  logic [lr_pkg::COLOUR_W-1:0]  line_colour,
  input  logic                         q_full,
  output logic                         q_push,
  output lr_pkg::cmd_t                 q_cmd
);
  import lr_pkg::*;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [COORD_W-1:0] ay, by, dx, dy;
  logic               steep;
  logic [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
  logic [COORD_W-1:0] lo_maj, lo_min, hi_maj, hi_min;
  logic [COORD_W-1:0] maj_delta;

  // handshake: stall only on a full queue
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // octant: swap axes for steep lines, then order by major coordinate
  always_comb begin
    ay    = {1'b0, start_y};
    by    = {1'b0, end_y};
    dx    = abs_diff(start_x, end_x);
    dy    = abs_diff(ay, by);
    steep = dy > dx;
    if (steep) begin
      a_maj = ay;      a_min = start_x;
      b_maj = by;      b_min = end_x;
    end else begin
      a_maj = start_x; a_min = ay;
      b_maj = end_x;   b_min = by;
    end
    if (a_maj > b_maj) begin
      lo_maj = b_maj; lo_min = b_min;
      hi_maj = a_maj; hi_min = a_min;
    end else begin
      lo_maj = a_maj; lo_min = a_min;
      hi_maj = b_maj; hi_min = b_min;
    end
    maj_delta = hi_maj - lo_maj;
  end

  // command word
  always_comb begin
    q_cmd.op          = op_t'(operation);
    q_cmd.steep       = steep;
    q_cmd.minor_down  = !(lo_min < hi_min);
    q_cmd.major_pos   = lo_maj;
    q_cmd.major_end   = hi_maj;
    q_cmd.minor_pos   = lo_min;
    q_cmd.major_delta = maj_delta;
    q_cmd.minor_delta = abs_diff(lo_min, hi_min);
    // error starts at minus half the major delta
    q_cmd.error_init  = ERR_W'(0) - {2'b00, maj_delta[COORD_W-1:1]};
    q_cmd.colour      = line_colour;
  end

endmodule

// ----- design/lr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_queue: command queue
// Small FIFO that decouples the front end from the drawing engine.
// ----------------------------------------------------------------------------
module lr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lr_pkg::cmd_t  push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lr_pkg::cmd_t  head_cmd
);
  import lr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on pop");

endmodule

// ----- design/lr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_back: drawing engine
// Holds the Bresenham state, takes one command word per cycle while the output
// register is free, and emits one pixel write per step into the output register.
// ----------------------------------------------------------------------------
module lr_back #(
  parameter int ROW_SHIFT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  lr_pkg::cmd_t                  q_cmd,
  output logic                          q_pop,
  input  logic [lr_pkg::ADDR_W-1:0]     frame_base_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lr_pkg::COORD_W-1:0]    pixel_x,
  output logic [lr_pkg::ROW_W-1:0]      pixel_y,
  output logic [lr_pkg::ADDR_W-1:0]     pixel_address,
  output logic [lr_pkg::COLOUR_W-1:0]   pixel_colour,
  output logic                          last_pixel
);
  import lr_pkg::*;

  // line state
  logic                 active;
  logic                 steep;
  logic                 minor_down;
  logic [COORD_W-1:0]   major_pos, major_end, minor_pos;
  logic [COORD_W-1:0]   major_delta, minor_delta;
  logic [ERR_W-1:0]     error_acc;
  logic [COLOUR_W-1:0]  held_colour;

  logic                 slot_free, take, is_start, emit, at_end;
  logic [COORD_W-1:0]   px, py;
  logic [ERR_W:0]       err_sum, err_next;
  logic                 minor_move;
  logic [ADDR_W-1:0]    addr;

  // take a word whenever the output register can accept a result
  assign slot_free = !out_valid || !out_stall;
  assign take      = q_valid && slot_free;
  assign q_pop     = take;
  assign is_start  = (q_cmd.op == OP_START);
  assign emit      = take && !is_start && active;

  // pixel and next step
  always_comb begin
    px         = steep ? minor_pos : major_pos;
    py         = steep ? major_pos : minor_pos;
    at_end     = (major_pos == major_end);
    addr       = frame_base_address
               + (ADDR_W'(py) << ROW_SHIFT)
               + {{(ADDR_W-COORD_W-1){1'b0}}, px, 1'b0};
    err_sum    = {error_acc[ERR_W-1], error_acc} + {2'b00, minor_delta};
    minor_move = !err_sum[ERR_W] && (err_sum != '0);
    err_next   = minor_move ? (err_sum - {2'b00, major_delta}) : err_sum;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      steep       <= 1'b0;
      minor_down  <= 1'b0;
      major_pos   <= '0;
      major_end   <= '0;
      minor_pos   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_acc   <= '0;
      held_colour <= '0;
    end else if (take && is_start) begin
      active      <= 1'b1;
      steep       <= q_cmd.steep;
      minor_down  <= q_cmd.minor_down;
      major_pos   <= q_cmd.major_pos;
      major_end   <= q_cmd.major_end;
      minor_pos   <= q_cmd.minor_pos;
      major_delta <= q_cmd.major_delta;
      minor_delta <= q_cmd.minor_delta;
      error_acc   <= q_cmd.error_init;
      held_colour <= q_cmd.colour;
    end else if (emit) begin
      if (at_end) begin
        active <= 1'b0;
      end else begin
        if (minor_move) begin
          minor_pos <= minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        end
        error_acc <= err_next[ERR_W-1:0];
        major_pos <= major_pos + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x       <= px;
      pixel_y       <= py[ROW_W-1:0];
      pixel_address <= addr;
      pixel_colour  <= held_colour;
      last_pixel    <= at_end;
    end
  end

  // checks
  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    (emit && at_end) |=> !active)
    else $error("engine still active after final pixel");
  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    (take && !is_start && !active) |=> !out_valid)
    else $error("pixel emitted for a step while idle");

endmodule

// ----- design/line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line engine with frame buffer addressing
// Front end, command queue and drawing engine, plus the APB register.
// ----------------------------------------------------------------------------
// A start word (operation 0) loads two endpoints and a color and gives no
// output; each following step word (operation 1) gives one pixel write with
// x, y, byte address (base + row << ROW_SHIFT + column * 2), color and a flag
// on the final endpoint. Both endpoints are drawn; steps while idle give
// nothing. Throughput is one word per clock, start or step, while the output
// is not stalled, set by the drawing engine taking one queued word per cycle.
// An accepted step word is written into the queue and, once the engine takes
// it, into the output register that presents its pixel. A QUEUE_DEPTH-entry
// queue sits between input and engine, so input keeps flowing while the
// output is stalled until the queue fills.
// Write frame_base_address (offset 0) only while no line is in flight.
module line_rasterizer #(
  parameter int ROW_SHIFT   = 10,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [lr_pkg::COORD_W-1:0]    start_x,
  input  logic [lr_pkg::ROW_W-1:0]      start_y,
  input  logic [lr_pkg::COORD_W-1:0]    end_x,
  input  logic [lr_pkg::ROW_W-1:0]      end_y,
  input  logic [lr_pkg::COLOUR_W-1:0]   line_colour,
  // pixel writes
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lr_pkg::COORD_W-1:0]    pixel_x,
  output logic [lr_pkg::ROW_W-1:0]      pixel_y,
  output logic [lr_pkg::ADDR_W-1:0]     pixel_address,
  output logic [lr_pkg::COLOUR_W-1:0]   pixel_colour,
  output logic                          last_pixel
);
  import lr_pkg::*;

  localparam logic REG_FRAME_BASE = 1'b0;  // word index of frame_base_address

  logic [ADDR_W-1:0] frame_base_address;
  logic              reg_hit;
  logic              q_full, q_push, q_pop, q_valid;
  cmd_t              push_cmd, head_cmd;

  // register access
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_FRAME_BASE);
  assign prdata  = reg_hit ? frame_base_address : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base_address <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      frame_base_address <= pwdata;
    end
  end

  // front end
  lr_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_colour (line_colour),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  // command queue
  lr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  // drawing engine
  lr_back #(
    .ROW_SHIFT (ROW_SHIFT)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_cmd              (head_cmd),
    .q_pop              (q_pop),
    .frame_base_address (frame_base_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pixel_x            (pixel_x),
    .pixel_y            (pixel_y),
    .pixel_address      (pixel_address),
    .pixel_colour       (pixel_colour),
    .last_pixel         (last_pixel)
  );

endmodule
